// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the bit packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define HCBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property, checked during reset too.
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== hdl/hcbp_pkg.sv =====
// Types and constants of the Huffman code bit packer.
`timescale 1ns / 1ps
package hcbp_pkg;

   localparam int FUNC_W      = 2;
   localparam int SYM_W       = 8;
   localparam int CODE_BITS_W = 32;
   localparam int CODE_LEN_W  = 6;
   localparam int BYTE_W      = 8;
   localparam int PAD_W       = 3;
   localparam int PEND_W      = 7;
   localparam int TABLE_DEPTH = 256;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_FLUSH  = 2'd2
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [SYM_W-1:0]       symbol;
      logic [CODE_BITS_W-1:0] code_bits;
      logic [CODE_LEN_W-1:0]  code_len;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic [PAD_W-1:0]  pad_count;
      logic              last;
   } rsp_type;

endpackage

// ===== hdl/hcbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/huffman_code_bit_packer_unit.sv =====
// Top level of the Huffman code bit packer: code table, packer and output queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   req_* : request word {func, symbol, code_bits, code_len}, valid/ready.
//           func load writes a table entry, encode packs the code of a byte,
//           flush pads the pending bits to a byte boundary.
//   rsp_* : result word {out_byte, has_byte, pad_count, last}, valid/ready.
//           last marks the final result of a request.
// Path: the edge that takes a request reads the table into the packing stage;
//   the result is packed into the output register when that stage advances.
// Throughput: one request per cycle while rsp_ready is high and each request
//   yields at most one result. An encode that completes more than one byte holds
//   the packing stage until its bytes drain, since the single output register drains
//   one byte per cycle while rsp_ready is high; up to (7 + MAX_CODE_LEN) / 8 bytes, four at the default code length.
// Reset: synchronous. All table entries read as empty (length zero) until
//   loaded, the bit accumulator is cleared and both stages are emptied.
// Stall: while rsp_ready is low the output register and byte queue hold;
//   the packing stage and then req_ready back up behind them.
module huffman_code_bit_packer_unit #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hcbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hcbp_pkg::rsp_type rsp_data
);

   import hcbp_pkg::*;

   localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
   localparam int TOT_W     = $clog2(MAX_CODE_LEN + 8);
   localparam int MAX_BYTES = (MAX_CODE_LEN + 7) / 8;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int BUF_W     = 8 * (MAX_BYTES + 1);
   localparam int ENT_W     = MAX_CODE_LEN + LEN_W;
   localparam int EXT_W     = MAX_CODE_LEN + CODE_BITS_W;

   // ---------------------------------------------------------------------
   // Stage 0: accept, table write and table read
   // ---------------------------------------------------------------------
   logic                    req_acc;
   logic                    tab_wr;
   logic [LEN_W-1:0]        len_clip;
   logic [LEN_W-1:0]        lj_shift;
   logic [EXT_W-1:0]        code_ext;
   logic [ENT_W-1:0]        tab_wr_data;
   logic [ENT_W-1:0]        tab_rd_data;

   logic                    tab_ok_ff [TABLE_DEPTH];
   logic                    s1_valid_ff, s1_valid_in;
   logic [FUNC_W-1:0]       s1_func_ff;
   logic                    s1_tab_ok_ff;

   assign req_acc = req_valid && req_ready;
   assign tab_wr  = req_acc && (req_data.func == FUNC_LOAD);

   // Saturate the length, then store the code left justified so the packer
   // only shifts by the pending count. Bits above the length fall off the top.
   always_comb begin
      if (req_data.code_len > CODE_LEN_W'(MAX_CODE_LEN)) begin
         len_clip = LEN_W'(MAX_CODE_LEN);
      end else begin
         len_clip = LEN_W'(req_data.code_len);
      end
      lj_shift    = LEN_W'(MAX_CODE_LEN) - len_clip;
      code_ext    = EXT_W'(req_data.code_bits) << lj_shift;
      tab_wr_data = {len_clip, code_ext[MAX_CODE_LEN-1:0]};
   end

   hcbp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (tab_wr),
      .wr_addr (req_data.symbol),
      .wr_data (tab_wr_data),
      .rd_en   (req_acc),
      .rd_addr (req_data.symbol),
      .rd_data (tab_rd_data)
   );

   // Per-entry loaded flags: an entry never loaded reads as length zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            tab_ok_ff[i] <= 1'b0;
         end
      end else if (tab_wr) begin
         tab_ok_ff[req_data.symbol] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: pack pending bits and code
   // ---------------------------------------------------------------------
   logic [PEND_W-1:0]       pend_ff, pend_in;      // left justified
   logic [PAD_W-1:0]        pend_cnt_ff, pend_cnt_in;
   logic [LEN_W-1:0]        tab_len;
   logic [MAX_CODE_LEN-1:0] tab_code;
   logic [TOT_W-1:0]        total;
   logic [CNT_W-1:0]        nbytes;
   logic [BUF_W-1:0]        packed_bits;
   logic [BYTE_W-1:0]       jbytes [MAX_BYTES+1];
   logic [PEND_W-1:0]       enc_pend;

   always_comb begin
      if (s1_tab_ok_ff) begin
         tab_len  = tab_rd_data[ENT_W-1:MAX_CODE_LEN];
         tab_code = tab_rd_data[MAX_CODE_LEN-1:0];
      end else begin
         tab_len  = '0;
         tab_code = '0;
      end
      total       = TOT_W'(pend_cnt_ff) + TOT_W'(tab_len);
      nbytes      = CNT_W'(total >> 3);
      packed_bits = {pend_ff, (BUF_W - PEND_W)'(0)}
                  | ({tab_code, (BUF_W - MAX_CODE_LEN)'(0)} >> pend_cnt_ff);
      for (int k = 0; k <= MAX_BYTES; k++) begin
         jbytes[k] = packed_bits[BUF_W-1-8*k -: 8];
      end
      // leftover bits start right after the last whole byte
      enc_pend = '0;
      for (int k = 0; k <= MAX_BYTES; k++) begin
         if (nbytes == CNT_W'(k)) begin
            enc_pend = jbytes[k][7:1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register and byte queue
   // ---------------------------------------------------------------------
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [BYTE_W-1:0]       q_ff [MAX_BYTES];
   logic [BYTE_W-1:0]       q_in [MAX_BYTES];
   logic [CNT_W-1:0]        q_cnt_ff, q_cnt_in;
   logic                    emit_free;
   logic                    s1_adv;

   assign emit_free = !rsp_valid_ff || (rsp_ready && (q_cnt_ff == '0));
   assign s1_adv    = s1_valid_ff && emit_free;
   assign req_ready = !s1_valid_ff || emit_free;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      q_in         = q_ff;
      q_cnt_in     = q_cnt_ff;
      pend_in      = pend_ff;
      pend_cnt_in  = pend_cnt_ff;

      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_ready && (q_cnt_ff != '0)) begin
         // drain the next queued byte of the current encode
         rsp_in.out_byte  = q_ff[0];
         rsp_in.has_byte  = 1'b1;
         rsp_in.pad_count = '0;
         rsp_in.last      = (q_cnt_ff == CNT_W'(1));
         for (int k = 0; k < MAX_BYTES - 1; k++) begin
            q_in[k] = q_ff[k+1];
         end
         q_cnt_in = q_cnt_ff - CNT_W'(1);
      end else if (s1_adv) begin
         rsp_valid_in = 1'b0;
         case (s1_func_ff)
            FUNC_ENCODE: begin
               pend_in     = enc_pend;
               pend_cnt_in = total[PAD_W-1:0];
               if (nbytes != '0) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.out_byte  = jbytes[0];
                  rsp_in.has_byte  = 1'b1;
                  rsp_in.pad_count = '0;
                  rsp_in.last      = (nbytes == CNT_W'(1));
                  for (int k = 0; k < MAX_BYTES; k++) begin
                     q_in[k] = jbytes[k+1];
                  end
                  q_cnt_in = nbytes - CNT_W'(1);
               end
            end
            FUNC_FLUSH: begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_byte  = {pend_ff, 1'b0};
               rsp_in.has_byte  = (pend_cnt_ff != '0);
               rsp_in.pad_count = PAD_W'(4'd8 - {1'b0, pend_cnt_ff});
               rsp_in.last      = 1'b1;
               pend_in          = '0;
               pend_cnt_in      = '0;
            end
            default: begin
               // load already written in stage 0; unused code does nothing
            end
         endcase
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         q_cnt_ff     <= '0;
         pend_ff      <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         q_cnt_ff     <= q_cnt_in;
         pend_ff      <= pend_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_func_ff   <= req_data.func;
         s1_tab_ok_ff <= tab_ok_ff[req_data.symbol];
      end
      rsp_ff <= rsp_in;
      q_ff   <= q_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `HCBP_ASSERT(a_queue_needs_rsp, clock, reset,
      (q_cnt_ff != '0) |-> rsp_valid_ff, "byte queue holds data with no result shown")
   `HCBP_ASSERT(a_no_early_last, clock, reset,
      (rsp_valid_ff && (q_cnt_ff != '0)) |-> !rsp_ff.last, "last set with bytes still queued")
   `HCBP_ASSERT(a_pend_clean, clock, reset,
      (pend_cnt_ff == '0) |-> (pend_ff == '0), "pending bits left over with count zero")
   `HCBP_ASSERT(a_flush_empties, clock, reset,
      (s1_adv && (s1_func_ff == FUNC_FLUSH)) |=> (pend_cnt_ff == '0),
      "accumulator not empty after flush")
   `HCBP_ASSERT(a_empty_stage_ready, clock, reset,
      !s1_valid_ff |-> req_ready, "request refused with packing stage empty")

endmodule

// ===== tb/huffman_code_bit_packer_unit_tb.sv =====
// Testbench of the Huffman code bit packer: directed and random words against a predictor.
`timescale 1ns / 1ps
module huffman_code_bit_packer_unit_tb;
   import hcbp_pkg::*;

   localparam int MAX_CODE_LEN = 32;
   // func code the block must ignore
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 420;
   localparam int PHASES = 4;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   huffman_code_bit_packer_unit #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the block: code table and bit accumulator.
   logic [CODE_LEN_W-1:0]  code_len_tbl  [TABLE_DEPTH];
   logic [CODE_BITS_W-1:0] code_bits_tbl [TABLE_DEPTH];
   logic [PEND_W-1:0]      pend_bits;
   int                     pend_cnt;

   // Output bytes predicted but not yet seen on rsp, oldest first.
   rsp_type expected_bytes[$];
   rsp_type want_word;
   int      err_count;

   // Idle odds in percent per cycle; changed between phases.
   int req_idle_pct;
   int rsp_stall_pct;

   // Symbols that currently hold a code, so random encodes mostly hit.
   logic [SYM_W-1:0] loaded_syms[$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      err_count++;
   endtask

   // Advance the shadow state by one accepted request word and queue every
   // output byte it produces.
   task automatic predict_bytes(input req_type w);
      logic [CODE_LEN_W-1:0] len;
      logic [63:0]           acc;
      int                    total;
      int                    nbytes;
      int                    rem;
      rsp_type               r;
      case (w.func)
         FUNC_LOAD: begin
            // over-long lengths clip to the maximum; bits above the length drop
            len = (w.code_len > MAX_CODE_LEN) ? CODE_LEN_W'(MAX_CODE_LEN) : w.code_len;
            code_len_tbl[w.symbol]  = len;
            code_bits_tbl[w.symbol] = w.code_bits & 32'((64'd1 << len) - 64'd1);
         end
         FUNC_ENCODE: begin
            len = code_len_tbl[w.symbol];
            if (len != 0) begin
               acc    = (64'(pend_bits) << len) | 64'(code_bits_tbl[w.symbol]);
               total  = pend_cnt + int'(len);
               nbytes = total / 8;
               rem    = total % 8;
               for (int i = 0; i < nbytes; i++) begin
                  r.out_byte  = 8'(acc >> (total - 8 * (i + 1)));
                  r.has_byte  = 1'b1;
                  r.pad_count = '0;
                  r.last      = (i == nbytes - 1);
                  expected_bytes = {expected_bytes, r};
               end
               pend_bits = PEND_W'(acc & ((64'd1 << rem) - 64'd1));
               pend_cnt  = rem;
            end
         end
         FUNC_FLUSH: begin
            r.last = 1'b1;
            if (pend_cnt == 0) begin
               r.out_byte  = '0;
               r.has_byte  = 1'b0;
               r.pad_count = '0;
            end else begin
               r.out_byte  = 8'(16'(pend_bits) << (8 - pend_cnt));
               r.has_byte  = 1'b1;
               r.pad_count = PAD_W'(8 - pend_cnt);
            end
            expected_bytes = {expected_bytes, r};
            pend_bits = '0;
            pend_cnt  = 0;
         end
         default: begin
            // unused func: no state change, no output
         end
      endcase
   endtask

   // Monitor: check the output word first, then fold in the request word
   // taken at the same edge. A request never yields a byte at its own edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_data));
            end else begin
               want_word = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want_word.out_byte)
                  report_mismatch($sformatf("out_byte got %h want %h",
                                            rsp_data.out_byte, want_word.out_byte));
               if (rsp_data.has_byte !== want_word.has_byte)
                  report_mismatch($sformatf("has_byte got %b want %b",
                                            rsp_data.has_byte, want_word.has_byte));
               if (rsp_data.pad_count !== want_word.pad_count)
                  report_mismatch($sformatf("pad_count got %0d want %0d",
                                            rsp_data.pad_count, want_word.pad_count));
               if (rsp_data.last !== want_word.last)
                  report_mismatch($sformatf("last got %b want %b",
                                            rsp_data.last, want_word.last));
            end
         end
         if (req_valid && req_ready) begin
            predict_bytes(req_data);
         end
      end
   end

   // Receiver back-pressure, redrawn each cycle.
   always @(posedge clock) begin
      rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic req_type req_word(input logic [FUNC_W-1:0] func,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [CODE_BITS_W-1:0] bits,
                                        input logic [CODE_LEN_W-1:0] len);
      req_type w;
      w.func      = func;
      w.symbol    = sym;
      w.code_bits = bits;
      w.code_len  = len;
      return w;
   endfunction

   // Present one request word and hold it until taken. Called at a rising
   // edge; returns at the edge that accepted the word.
   task automatic send_word(input req_type w);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lookups before any load: every entry is an empty code.
   task automatic test_empty_table();
      send_word(req_word(FUNC_ENCODE, 8'h00, '0, '0));
      send_word(req_word(FUNC_ENCODE, 8'hFF, '0, '0));
      send_word(req_word(FUNC_FLUSH, '0, '0, '0));          // nothing pending
      send_word(req_word(FUNC_LOAD, 8'h80, 32'hFFFF_FFFF, 6'd0));
      send_word(req_word(FUNC_ENCODE, 8'h80, '0, '0));      // empty code
   endtask

   // Longest codes, clipped lengths, masking, flushes with seven, four and no bits pending.
   task automatic test_code_extremes();
      send_word(req_word(FUNC_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32));
      send_word(req_word(FUNC_LOAD, 8'h5A, 32'h0000_005A, 6'd7));
      send_word(req_word(FUNC_LOAD, 8'hA5, 32'h1234_5678, 6'd63)); // clipped to 32
      send_word(req_word(FUNC_LOAD, 8'h0F, 32'h8000_0001, 6'd33)); // clipped to 32
      send_word(req_word(FUNC_LOAD, 8'h3C, 32'hFFFF_FFFF, 6'd3));  // high bits dropped
      send_word(req_word(FUNC_LOAD, 8'hFF, 32'h0000_0000, 6'd1));
      send_word(req_word(FUNC_ENCODE, 8'h5A, '0, '0));     // seven pending, no byte
      send_word(req_word(FUNC_ENCODE, 8'h00, '0, '0));     // 39 bits: four bytes
      send_word(req_word(FUNC_FLUSH, '0, '0, '0));         // pad of one
      send_word(req_word(FUNC_ENCODE, 8'h3C, '0, '0));
      send_word(req_word(FUNC_ENCODE, 8'hFF, '0, '0));
      send_word(req_word(FUNC_FLUSH, '0, '0, '0));         // pad of four
      send_word(req_word(FUNC_ENCODE, 8'hA5, '0, '0));     // aligned, four bytes
      send_word(req_word(FUNC_ENCODE, 8'h0F, '0, '0));
      send_word(req_word(FUNC_FLUSH, '0, '0, '0));
   endtask

   // func 3 must leave the table and accumulator alone.
   task automatic test_unused_func();
      send_word(req_word(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
      send_word(req_word(FUNC_ENCODE, 8'h3C, '0, '0));
      send_word(req_word(FUNC_UNUSED, 8'h3C, 32'h0000_0000, 6'd0));
      send_word(req_word(FUNC_FLUSH, '0, '0, '0));
   endtask

   function automatic logic [CODE_LEN_W-1:0] random_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)  return '0;
      if (pick < 75) return CODE_LEN_W'($urandom_range(12, 1));
      if (pick < 92) return CODE_LEN_W'($urandom_range(32, 13));
      return CODE_LEN_W'($urandom_range(63, 33));
   endfunction

   // Mostly encodes of loaded symbols with flushes mixed in; some reloads,
   // stray lookups and ignored func 3 words.
   task automatic test_random_traffic(input int words, input int idle_pct,
                                      input int stall_pct);
      int               sent;
      int               pick;
      logic [SYM_W-1:0] sym;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < words) begin
         pick = $urandom_range(99);
         if (loaded_syms.size() < 8 || (pick >= 80 && pick < 92)) begin
            sym = SYM_W'($urandom_range(255));
            send_word(req_word(FUNC_LOAD, sym, $urandom, random_len()));
            loaded_syms = {loaded_syms, sym};
            if (loaded_syms.size() > 24) void'(loaded_syms.pop_front());
            sent++;
         end else if (pick < 70) begin
            sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
            send_word(req_word(FUNC_ENCODE, sym, $urandom, CODE_LEN_W'($urandom)));
            sent++;
         end else if (pick < 80) begin
            send_word(req_word(FUNC_FLUSH, SYM_W'($urandom), $urandom,
                               CODE_LEN_W'($urandom)));
            sent++;
         end else if (pick < 97) begin
            send_word(req_word(FUNC_ENCODE, SYM_W'($urandom), $urandom,
                               CODE_LEN_W'($urandom)));
            sent++;
         end else begin
            // ignored word, not counted
            send_word(req_word(FUNC_UNUSED, SYM_W'($urandom), $urandom,
                               CODE_LEN_W'($urandom)));
         end
      end
   endtask

   initial begin
      int drain;
      err_count     = 0;
      pend_bits     = '0;
      pend_cnt      = 0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         code_len_tbl[i]  = '0;
         code_bits_tbl[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_code_extremes();
      req_idle_pct  = 30;
      rsp_stall_pct = 30;
      test_unused_func();

      test_random_traffic(RANDOM_WORDS / PHASES, 0, 0);
      test_random_traffic(RANDOM_WORDS / PHASES, 51, 0);
      test_random_traffic(RANDOM_WORDS / PHASES, 0, 51);
      test_random_traffic(RANDOM_WORDS / PHASES, 36, 36);
      req_valid <= 1'b0;

      // drain outstanding bytes, then let the pipe settle
      drain = 0;
      while (expected_bytes.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
      end

      if (err_count == 0) begin
         $display("huffman_code_bit_packer_unit_tb: done, clean");
      end else begin
         $display("huffman_code_bit_packer_unit_tb: done, errors");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("huffman_code_bit_packer_unit_tb: done, errors");
      $finish;
   end

endmodule
